// File: rtl/ecvm_pkg.sv
// shared types, widths and constants of the euler camera view matrix block
// no dependencies
package ecvm_pkg;

   localparam int UNIT_FRAC_BITS_DEF = 14;
   localparam int TRIG_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES = 30;
   localparam int QUEUE_DEPTH = 2;

   localparam int ANG_W = 16;
   localparam int POS_W = 32;
   localparam int UNIT_W = 16;
   localparam int SHIFT_W = 34;
   localparam int Z_W = 32;
   localparam int TW = 34;

   localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [2:0]               flip;
      logic [2:0][Z_W-1:0]      z;
      logic [2:0][POS_W-1:0]    pos;
   } item_type;

   function automatic logic signed [TW-1:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0:    return 34'sd843314857;
         5'd1:    return 34'sd497837829;
         5'd2:    return 34'sd263043837;
         5'd3:    return 34'sd133525159;
         5'd4:    return 34'sd67021687;
         5'd5:    return 34'sd33543516;
         5'd6:    return 34'sd16775851;
         5'd7:    return 34'sd8388437;
         5'd8:    return 34'sd4194283;
         5'd9:    return 34'sd2097149;
         5'd10:   return 34'sd1048576;
         5'd11:   return 34'sd524288;
         5'd12:   return 34'sd262144;
         5'd13:   return 34'sd131072;
         5'd14:   return 34'sd65536;
         5'd15:   return 34'sd32768;
         5'd16:   return 34'sd16384;
         5'd17:   return 34'sd8192;
         5'd18:   return 34'sd4096;
         5'd19:   return 34'sd2048;
         5'd20:   return 34'sd1024;
         5'd21:   return 34'sd512;
         5'd22:   return 34'sd256;
         5'd23:   return 34'sd128;
         5'd24:   return 34'sd64;
         5'd25:   return 34'sd32;
         5'd26:   return 34'sd16;
         5'd27:   return 34'sd8;
         5'd28:   return 34'sd4;
         5'd29:   return 34'sd2;
         default: return 34'sd0;
      endcase
   endfunction

endpackage

// File: rtl/ecvm_front.sv
// front end: angle reduction, folding and conversion to q2.30 radians
// depends on ecvm_pkg
module ecvm_front (
   input  logic                            req_valid,
   input  logic                            queue_ready,
   input  logic signed [ecvm_pkg::ANG_W-1:0] pitch_deg,
   input  logic signed [ecvm_pkg::ANG_W-1:0] yaw_deg,
   input  logic signed [ecvm_pkg::ANG_W-1:0] roll_deg,
   input  logic signed [ecvm_pkg::POS_W-1:0] pos_x,
   input  logic signed [ecvm_pkg::POS_W-1:0] pos_y,
   input  logic signed [ecvm_pkg::POS_W-1:0] pos_z,
   output logic                            push,
   output ecvm_pkg::item_type              item
);
   import ecvm_pkg::*;

   localparam int AW = ANG_W + 1;
   localparam int KW = 20;
   localparam int PW = AW + KW;
   localparam logic signed [AW-1:0] A_FULL = 17'sd23040;
   localparam logic signed [AW-1:0] A_HALF = 17'sd11520;
   localparam logic signed [AW-1:0] A_QUARTER = 17'sd5760;
   localparam logic signed [KW-1:0] K_RAD = 20'sd292818;

   function automatic logic [Z_W:0] conv(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] r;
      logic                 flip;
      logic signed [PW-1:0] prod;
      r = a;
      flip = 1'b0;
      if (a >= A_FULL) begin
         r = a - A_FULL;
      end else if (a <= -A_FULL) begin
         r = a + A_FULL;
      end
      if (r < 0) begin
         r = r + A_FULL;
      end
      if (r >= A_HALF) begin
         r = r - A_FULL;
      end
      if (r > A_QUARTER) begin
         r = A_HALF - r;
         flip = 1'b1;
      end else if (r < -A_QUARTER) begin
         r = -A_HALF - r;
         flip = 1'b1;
      end
      prod = PW'(r) * PW'(K_RAD);
      return {flip, prod[Z_W-1:0]};
   endfunction

   logic [Z_W:0] cp, cy, cr;

   always_comb begin
      cp = conv(AW'(pitch_deg));
      cy = conv(-AW'(yaw_deg));
      cr = conv(AW'(roll_deg));
      item.flip = {cr[Z_W], cy[Z_W], cp[Z_W]};
      item.z[0] = cp[Z_W-1:0];
      item.z[1] = cy[Z_W-1:0];
      item.z[2] = cr[Z_W-1:0];
      item.pos[0] = pos_x;
      item.pos[1] = pos_y;
      item.pos[2] = pos_z;
   end

   assign push = req_valid && queue_ready;

endmodule

// File: rtl/ecvm_queue.sv
// short queue between the front end and the back end
// depends on ecvm_pkg
module ecvm_queue #(
   parameter int DEPTH = ecvm_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ecvm_pkg::item_type push_item,
   output logic               ready,
   input  logic               pop,
   output logic               nonempty,
   output ecvm_pkg::item_type pop_item
);
   import ecvm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             items_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in = push ? bump(wr_ff) : wr_ff;
      rd_in = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         items_ff[wr_ff] <= push_item;
      end
   end

   assign ready = (count_ff < CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign pop_item = items_ff[rd_ff];

endmodule

// File: rtl/ecvm_back.sv
// back end: cordic lanes, shared multiplier sequence and dot products
// depends on ecvm_pkg
module ecvm_back #(
   parameter int UNIT_FRAC_BITS = ecvm_pkg::UNIT_FRAC_BITS_DEF,
   parameter int TRIG_STEPS = ecvm_pkg::TRIG_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_nonempty,
   input  ecvm_pkg::item_type                 q_item,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_side_x,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_side_y,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_side_z,
   output logic signed [ecvm_pkg::SHIFT_W-1:0] rsp_side_shift,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_up_x,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_up_y,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_up_z,
   output logic signed [ecvm_pkg::SHIFT_W-1:0] rsp_up_shift,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_back_x,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_back_y,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_back_z,
   output logic signed [ecvm_pkg::SHIFT_W-1:0] rsp_back_shift
);
   import ecvm_pkg::*;

   localparam int STEPS = (TRIG_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STEPS;
   localparam int UW = UNIT_FRAC_BITS + 2;
   localparam int PW = 2 * TW;
   localparam int MUL_LAST = 15;
   localparam int DOT_LAST = 9;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CORDIC = 3'd1;
   localparam logic [2:0] ST_MUL = 3'd2;
   localparam logic [2:0] ST_UNIT = 3'd3;
   localparam logic [2:0] ST_DOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam logic signed [PW-1:0] Q30_HALF = PW'(64'sd536870912);
   localparam logic signed [TW:0] UNIT_HALF = (TW+1)'(1) <<< (29 - UNIT_FRAC_BITS);
   localparam logic signed [TW:0] UNIT_ONE = (TW+1)'(1) <<< UNIT_FRAC_BITS;
   localparam logic signed [PW-1:0] DOT_HALF = PW'(1) <<< (UNIT_FRAC_BITS - 1);
   localparam logic signed [PW-1:0] SHIFT_MAX = (PW'(1) <<< (SHIFT_W - 1)) - 1;
   localparam logic signed [PW-1:0] SHIFT_MIN = -(PW'(1) <<< (SHIFT_W - 1));

   logic [2:0]                state_ff, state_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic signed [TW-1:0]      x_ff [3];
   logic signed [TW-1:0]      y_ff [3];
   logic signed [TW-1:0]      z_ff [3];
   logic [2:0]                flip_ff;
   logic signed [POS_W-1:0]   pos_ff [3];
   logic signed [PW-1:0]      prod_ff;
   logic signed [TW-1:0]      t0_ff, t1_ff;
   logic signed [TW-1:0]      up_ff [3];
   logic signed [TW-1:0]      fr_ff [3];
   logic signed [TW-1:0]      sd_ff [3];
   logic signed [UW-1:0]      su_ff [3];
   logic signed [UW-1:0]      uu_ff [3];
   logic signed [UW-1:0]      bu_ff [3];
   logic signed [PW-1:0]      acc_ff [3];
   logic                      out_valid_ff;

   logic signed [TW-1:0]      sx, cx, sy, cy, sz, cz;
   logic signed [TW-1:0]      mul_a, mul_b;
   logic signed [TW-1:0]      rnd;
   logic signed [TW-1:0]      atan_i;
   logic                      load_out;
   logic                      cordic_last;

   function automatic logic signed [UW-1:0] to_unit(input logic signed [TW-1:0] v);
      logic signed [TW:0] r;
      r = ((TW+1)'(v) + UNIT_HALF) >>> (30 - UNIT_FRAC_BITS);
      if (r > UNIT_ONE) begin
         r = UNIT_ONE;
      end else if (r < -UNIT_ONE) begin
         r = -UNIT_ONE;
      end
      return UW'(r);
   endfunction

   function automatic logic signed [SHIFT_W-1:0] to_shift(input logic signed [PW-1:0] a);
      logic signed [PW-1:0] r;
      r = -((a + DOT_HALF) >>> UNIT_FRAC_BITS);
      if (r > SHIFT_MAX) begin
         r = SHIFT_MAX;
      end else if (r < SHIFT_MIN) begin
         r = SHIFT_MIN;
      end
      return SHIFT_W'(r);
   endfunction

   always_comb begin
      sx = y_ff[0];
      sy = y_ff[1];
      sz = y_ff[2];
      cx = flip_ff[0] ? -x_ff[0] : x_ff[0];
      cy = flip_ff[1] ? -x_ff[1] : x_ff[1];
      cz = flip_ff[2] ? -x_ff[2] : x_ff[2];
      rnd = TW'((prod_ff + Q30_HALF) >>> 30);
      atan_i = atan_q30(cnt_ff);
      cordic_last = (cnt_ff == 5'(STEPS - 1));
      load_out = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);
      q_pop = (state_ff == ST_IDLE) && q_nonempty;
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL) begin
         case (cnt_ff)
            5'd0:    begin mul_a = sx;       mul_b = sy;       end
            5'd1:    begin mul_a = cy;       mul_b = sz;       end
            5'd2:    begin mul_a = t0_ff;    mul_b = cz;       end
            5'd3:    begin mul_a = cx;       mul_b = cz;       end
            5'd4:    begin mul_a = sx;       mul_b = cy;       end
            5'd5:    begin mul_a = sy;       mul_b = sz;       end
            5'd6:    begin mul_a = t0_ff;    mul_b = cz;       end
            5'd7:    begin mul_a = cx;       mul_b = sy;       end
            5'd8:    begin mul_a = cx;       mul_b = cy;       end
            5'd9:    begin mul_a = sx;       mul_b = up_ff[2]; end
            5'd10:   begin mul_a = fr_ff[2]; mul_b = up_ff[1]; end
            5'd11:   begin mul_a = fr_ff[2]; mul_b = up_ff[0]; end
            5'd12:   begin mul_a = fr_ff[0]; mul_b = up_ff[2]; end
            5'd13:   begin mul_a = fr_ff[0]; mul_b = up_ff[1]; end
            5'd14:   begin mul_a = sx;       mul_b = up_ff[0]; end
            default: begin mul_a = '0;       mul_b = '0;       end
         endcase
      end else if (state_ff == ST_DOT) begin
         case (cnt_ff)
            5'd0:    begin mul_a = TW'(su_ff[0]); mul_b = TW'(pos_ff[0]); end
            5'd1:    begin mul_a = TW'(su_ff[1]); mul_b = TW'(pos_ff[1]); end
            5'd2:    begin mul_a = TW'(su_ff[2]); mul_b = TW'(pos_ff[2]); end
            5'd3:    begin mul_a = TW'(uu_ff[0]); mul_b = TW'(pos_ff[0]); end
            5'd4:    begin mul_a = TW'(uu_ff[1]); mul_b = TW'(pos_ff[1]); end
            5'd5:    begin mul_a = TW'(uu_ff[2]); mul_b = TW'(pos_ff[2]); end
            5'd6:    begin mul_a = TW'(bu_ff[0]); mul_b = TW'(pos_ff[0]); end
            5'd7:    begin mul_a = TW'(bu_ff[1]); mul_b = TW'(pos_ff[1]); end
            5'd8:    begin mul_a = TW'(bu_ff[2]); mul_b = TW'(pos_ff[2]); end
            default: begin mul_a = '0;            mul_b = '0;             end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_nonempty) begin
               state_in = ST_CORDIC;
               cnt_in = '0;
            end
         end
         ST_CORDIC: begin
            if (cordic_last) begin
               state_in = ST_MUL;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MUL: begin
            if (cnt_ff == 5'(MUL_LAST)) begin
               state_in = ST_UNIT;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_UNIT: begin
            state_in = ST_DOT;
            cnt_in = '0;
         end
         ST_DOT: begin
            if (cnt_ff == 5'(DOT_LAST)) begin
               state_in = ST_DONE;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // cordic lanes, one iteration per cycle
   always_ff @(posedge clock) begin
      if (q_pop) begin
         flip_ff <= q_item.flip;
         for (int k = 0; k < 3; k++) begin
            x_ff[k] <= CORDIC_GAIN;
            y_ff[k] <= '0;
            z_ff[k] <= TW'($signed(q_item.z[k]));
            pos_ff[k] <= $signed(q_item.pos[k]);
         end
      end else if (state_ff == ST_CORDIC) begin
         for (int k = 0; k < 3; k++) begin
            if (!z_ff[k][TW-1]) begin
               x_ff[k] <= x_ff[k] - (y_ff[k] >>> cnt_ff);
               y_ff[k] <= y_ff[k] + (x_ff[k] >>> cnt_ff);
               z_ff[k] <= z_ff[k] - atan_i;
            end else begin
               x_ff[k] <= x_ff[k] + (y_ff[k] >>> cnt_ff);
               y_ff[k] <= y_ff[k] - (x_ff[k] >>> cnt_ff);
               z_ff[k] <= z_ff[k] + atan_i;
            end
         end
      end
   end

   // product register and write back of the previous step
   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
      if (state_ff == ST_MUL) begin
         case (cnt_ff)
            5'd1:    t0_ff <= rnd;
            5'd2:    t1_ff <= rnd;
            5'd3:    up_ff[0] <= rnd + t1_ff;
            5'd4:    up_ff[1] <= rnd;
            5'd5:    t0_ff <= rnd;
            5'd6:    t1_ff <= rnd;
            5'd7:    up_ff[2] <= t1_ff - rnd;
            5'd8:    fr_ff[0] <= -rnd;
            5'd9:    fr_ff[2] <= rnd;
            5'd10:   t0_ff <= rnd;
            5'd11:   sd_ff[0] <= t0_ff - rnd;
            5'd12:   t0_ff <= rnd;
            5'd13:   sd_ff[1] <= t0_ff - rnd;
            5'd14:   t0_ff <= rnd;
            5'd15:   sd_ff[2] <= t0_ff - rnd;
            default: t1_ff <= t1_ff;
         endcase
      end
      if (state_ff == ST_UNIT) begin
         fr_ff[1] <= sx;
         for (int k = 0; k < 3; k++) begin
            su_ff[k] <= to_unit(sd_ff[k]);
            uu_ff[k] <= to_unit(up_ff[k]);
            acc_ff[k] <= '0;
         end
         bu_ff[0] <= -to_unit(fr_ff[0]);
         bu_ff[1] <= -to_unit(sx);
         bu_ff[2] <= -to_unit(fr_ff[2]);
      end
      if (state_ff == ST_DOT) begin
         case (cnt_ff)
            5'd1, 5'd2, 5'd3: acc_ff[0] <= acc_ff[0] + prod_ff;
            5'd4, 5'd5, 5'd6: acc_ff[1] <= acc_ff[1] + prod_ff;
            5'd7, 5'd8, 5'd9: acc_ff[2] <= acc_ff[2] + prod_ff;
            default:          acc_ff[0] <= acc_ff[0];
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_side_x <= UNIT_W'(su_ff[0]);
         rsp_side_y <= UNIT_W'(su_ff[1]);
         rsp_side_z <= UNIT_W'(su_ff[2]);
         rsp_up_x <= UNIT_W'(uu_ff[0]);
         rsp_up_y <= UNIT_W'(uu_ff[1]);
         rsp_up_z <= UNIT_W'(uu_ff[2]);
         rsp_back_x <= UNIT_W'(bu_ff[0]);
         rsp_back_y <= UNIT_W'(bu_ff[1]);
         rsp_back_z <= UNIT_W'(bu_ff[2]);
         rsp_side_shift <= to_shift(acc_ff[0]);
         rsp_up_shift <= to_shift(acc_ff[1]);
         rsp_back_shift <= to_shift(acc_ff[2]);
      end
   end

   assign rsp_valid = out_valid_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result overwritten before taken");
   a_cordic_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (cnt_ff < 5'(STEPS)))
      else $error("cordic count out of range");
   a_reset_out: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result valid after reset");

endmodule

// File: rtl/euler_camera_view_matrix.sv
// top level of the euler camera view matrix block
// depends on ecvm_pkg, ecvm_front, ecvm_queue, ecvm_back
//
// usage:
//   req_ channel carries pitch, yaw, roll (q9.6 degrees) and a q16.16
//   position; rsp_ channel returns the side, up and back rows (q1.f)
//   and their translations (q17.16). both use valid/ready; a transaction
//   moves when valid and ready are high at a rising edge.
//   the front reduces the angles and writes a two-entry queue in the
//   accepting cycle. the back pops one transaction and runs three cordic
//   lanes for min(TRIG_STEPS, 30) iterations, fifteen products on one shared
//   multiplier, a rounding step, nine dot product terms and the load of
//   the output register. the back pops a new transaction only after it
//   has loaded the output register for the last one and gone back to idle.
//   req_ready stays high while the queue has room, also while a result
//   waits on rsp_ready; a stalled result holds the back in its last step.
//   reset is synchronous and empties the queue and the output register.
module euler_camera_view_matrix #(
   parameter int UNIT_FRAC_BITS = ecvm_pkg::UNIT_FRAC_BITS_DEF,
   parameter int TRIG_STEPS = ecvm_pkg::TRIG_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [ecvm_pkg::ANG_W-1:0]   req_pitch_deg,
   input  logic signed [ecvm_pkg::ANG_W-1:0]   req_yaw_deg,
   input  logic signed [ecvm_pkg::ANG_W-1:0]   req_roll_deg,
   input  logic signed [ecvm_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [ecvm_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [ecvm_pkg::POS_W-1:0]   req_pos_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_side_x,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_side_y,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_side_z,
   output logic signed [ecvm_pkg::SHIFT_W-1:0] rsp_side_shift,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_up_x,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_up_y,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_up_z,
   output logic signed [ecvm_pkg::SHIFT_W-1:0] rsp_up_shift,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_back_x,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_back_y,
   output logic signed [ecvm_pkg::UNIT_W-1:0]  rsp_back_z,
   output logic signed [ecvm_pkg::SHIFT_W-1:0] rsp_back_shift
);
   import ecvm_pkg::*;

   item_type push_item, pop_item;
   logic     push, pop, nonempty, queue_ready;

   ecvm_front u_front (
      .req_valid   (req_valid),
      .queue_ready (queue_ready),
      .pitch_deg   (req_pitch_deg),
      .yaw_deg     (req_yaw_deg),
      .roll_deg    (req_roll_deg),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .pos_z       (req_pos_z),
      .push        (push),
      .item        (push_item)
   );

   ecvm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .ready     (queue_ready),
      .pop       (pop),
      .nonempty  (nonempty),
      .pop_item  (pop_item)
   );

   ecvm_back #(
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS),
      .TRIG_STEPS     (TRIG_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_nonempty     (nonempty),
      .q_item         (pop_item),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_side_x     (rsp_side_x),
      .rsp_side_y     (rsp_side_y),
      .rsp_side_z     (rsp_side_z),
      .rsp_side_shift (rsp_side_shift),
      .rsp_up_x       (rsp_up_x),
      .rsp_up_y       (rsp_up_y),
      .rsp_up_z       (rsp_up_z),
      .rsp_up_shift   (rsp_up_shift),
      .rsp_back_x     (rsp_back_x),
      .rsp_back_y     (rsp_back_y),
      .rsp_back_z     (rsp_back_z),
      .rsp_back_shift (rsp_back_shift)
   );

   assign req_ready = queue_ready;

endmodule

// File: tb/testbench.sv
// testbench for the euler camera view matrix block
// depends on ecvm_pkg and euler_camera_view_matrix
`timescale 1ns / 100ps

module testbench;

   localparam int UNIT_BITS = ecvm_pkg::UNIT_FRAC_BITS_DEF;
   localparam int CORDIC_STEPS = ecvm_pkg::TRIG_STEPS_DEF;
   localparam longint SHIFT_HI = 64'sd8589934591;
   localparam longint SHIFT_LO = -64'sd8589934592;
   localparam int RANDOM_ITEMS = 1530;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic signed [15:0] roll;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } pose_type;

   typedef struct {
      logic [15:0] side[3];
      logic [33:0] side_shift;
      logic [15:0] up[3];
      logic [33:0] up_shift;
      logic [15:0] back[3];
      logic [33:0] back_shift;
   } view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_pitch_deg = '0, req_yaw_deg = '0, req_roll_deg = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_side_x, rsp_side_y, rsp_side_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;
   logic signed [15:0] rsp_back_x, rsp_back_y, rsp_back_z;
   logic signed [33:0] rsp_side_shift, rsp_up_shift, rsp_back_shift;

   pose_type pending_poses[$];
   view_type expected_views[$];
   int send_idle_pct = 28;
   int recv_idle_pct = 57;
   bit stimulus_done = 0;
   int errors = 0;
   longint cycle_count = 0;

   always #2 clock = ~clock;

   euler_camera_view_matrix DUT (.*);

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_asr(longint v, int s);
      if (s <= 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_asr(a * b, 30);
   endfunction

   function automatic void sin_cos(int ang, output longint s, output longint c);
      int r;
      bit flip;
      longint x, y, z, dx, dy;
      r = ang % 23040;
      flip = 0;
      x = 652032874;
      y = 0;
      if (r < 0) r += 23040;
      if (r >= 11520) r -= 23040;
      if (r > 5760) begin
         r = 11520 - r;
         flip = 1;
      end else if (r < -5760) begin
         r = -11520 - r;
         flip = 1;
      end
      z = longint'(r) * 292818;
      for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ecvm_pkg::atan_q30(i[4:0]);
         end else begin
            x += dx; y -= dy; z += ecvm_pkg::atan_q30(i[4:0]);
         end
      end
      s = y;
      c = flip ? -x : x;
   endfunction

   function automatic longint unit_round(longint v);
      longint one, r;
      one = 64'sd1 <<< UNIT_BITS;
      r = round_asr(v, 30 - UNIT_BITS);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r;
   endfunction

   function automatic logic [33:0] neg_dot(longint e[3], longint p[3]);
      longint r;
      r = -round_asr(e[0] * p[0] + e[1] * p[1] + e[2] * p[2], UNIT_BITS);
      if (r > SHIFT_HI) r = SHIFT_HI;
      if (r < SHIFT_LO) r = SHIFT_LO;
      return r[33:0];
   endfunction

   function automatic view_type camera_view(pose_type t);
      view_type v;
      longint sx, cx, sy, cy, sz, cz;
      longint up[3], fr[3], sd[3], su[3], uu[3], bu[3], p[3];
      p[0] = t.px; p[1] = t.py; p[2] = t.pz;
      sin_cos(int'(t.pitch), sx, cx);
      sin_cos(-int'(t.yaw), sy, cy);
      sin_cos(int'(t.roll), sz, cz);
      up[0] = qmul(qmul(sx, sy), cz) + qmul(cy, sz);
      up[1] = qmul(cx, cz);
      up[2] = -qmul(qmul(sx, cy), cz) + qmul(sy, sz);
      fr[0] = -qmul(cx, sy);
      fr[1] = sx;
      fr[2] = qmul(cx, cy);
      sd[0] = qmul(fr[1], up[2]) - qmul(fr[2], up[1]);
      sd[1] = qmul(fr[2], up[0]) - qmul(fr[0], up[2]);
      sd[2] = qmul(fr[0], up[1]) - qmul(fr[1], up[0]);
      for (int k = 0; k < 3; k++) begin
         su[k] = unit_round(sd[k]);
         uu[k] = unit_round(up[k]);
         bu[k] = -unit_round(fr[k]);
         v.side[k] = su[k][15:0];
         v.up[k] = uu[k][15:0];
         v.back[k] = bu[k][15:0];
      end
      v.side_shift = neg_dot(su, p);
      v.up_shift = neg_dot(uu, p);
      v.back_shift = neg_dot(bu, p);
      return v;
   endfunction

   function automatic void add_pose(int a, int b, int c, int x, int y, int z);
      pose_type t;
      t.pitch = 16'(a); t.yaw = 16'(b); t.roll = 16'(c);
      t.px = x; t.py = y; t.pz = z;
      pending_poses.push_back(t);
   endfunction

   function automatic int rand_angle();
      case ($urandom_range(3))
         0: return $urandom_range(65535);
         1: return int'($urandom_range(11520)) - 5760;
         2: return (int'($urandom_range(16)) - 8) * 1440 + int'($urandom_range(2)) - 1;
         default: return int'($urandom_range(46080)) - 23040;
      endcase
   endfunction

   function automatic int rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return int'($urandom_range(20000000)) - 10000000;
         2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return int'($urandom_range(2000)) - 1000;
      endcase
   endfunction

   initial begin
      add_pose(0, 0, 0, 0, 0, 0);
      add_pose(5760, 0, 0, 65536, 65536, 65536);
      add_pose(-5760, 11520, 5760, -65536, 0, 65536);
      add_pose(11520, -11520, -5760, 0, 0, 0);
      add_pose(23040, 46080, -23040, 1, -1, 1);
      add_pose(32767, -32768, 32767, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      add_pose(-32768, 32767, -32768, 32'h80000000, 32'h80000000, 32'h80000000);
      add_pose(-1, -1, -1, -1, -1, -1);
      add_pose(5761, 5759, -5761, 32'h7fffffff, 32'h80000000, 0);
      add_pose(2880, 2880, 2880, 12345678, -8765432, 3141592);
      add_pose(11519, 11521, -11521, 32'h80000000, 32'h7fffffff, 32'h80000000);
      add_pose(17280, -17280, 1, 65536 * 100, -65536 * 200, 65536 * 300);
      add_pose(16'h5555, 16'haaaa, 16'h5555, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
      add_pose(16'haaaa, 16'h5555, 16'haaaa, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         add_pose(rand_angle(), rand_angle(), rand_angle(), rand_pos(), rand_pos(), rand_pos());
      stimulus_done = 1;
   end

   // idle profile moves with progress through the queue
   always @(posedge clock) begin
      if (pending_poses.size() == 1000) begin
         send_idle_pct <= 57;
         recv_idle_pct <= 28;
      end else if (pending_poses.size() == 500) begin
         send_idle_pct <= 0;
         recv_idle_pct <= 0;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_views.push_back(camera_view(pending_poses.pop_front()));
         end
         if (pending_poses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_pitch_deg <= pending_poses[0].pitch;
            req_yaw_deg <= pending_poses[0].yaw;
            req_roll_deg <= pending_poses[0].roll;
            req_pos_x <= pending_poses[0].px;
            req_pos_y <= pending_poses[0].py;
            req_pos_z <= pending_poses[0].pz;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, logic [33:0] exp_v, logic [33:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s mismatch: expected %h actual %h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      view_type v;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               $display("%0t unexpected transaction", $realtime);
               errors++;
            end else begin
               v = expected_views.pop_front();
               check_field("side_x", 34'(v.side[0]), 34'(rsp_side_x[15:0]));
               check_field("side_y", 34'(v.side[1]), 34'(rsp_side_y[15:0]));
               check_field("side_z", 34'(v.side[2]), 34'(rsp_side_z[15:0]));
               check_field("side_shift", v.side_shift, rsp_side_shift);
               check_field("up_x", 34'(v.up[0]), 34'(rsp_up_x[15:0]));
               check_field("up_y", 34'(v.up[1]), 34'(rsp_up_y[15:0]));
               check_field("up_z", 34'(v.up[2]), 34'(rsp_up_z[15:0]));
               check_field("up_shift", v.up_shift, rsp_up_shift);
               check_field("back_x", 34'(v.back[0]), 34'(rsp_back_x[15:0]));
               check_field("back_y", 34'(v.back[1]), 34'(rsp_back_y[15:0]));
               check_field("back_z", 34'(v.back[2]), 34'(rsp_back_z[15:0]));
               check_field("back_shift", v.back_shift, rsp_back_shift);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      while (pending_poses.size() > 0 || req_valid || expected_views.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_views.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
